/* hdl/column_post_sprite_blitter_unit_macros.svh */
// assertion macros for the column post sprite blitter checker
`ifndef COLUMN_POST_SPRITE_BLITTER_UNIT_MACROS_SVH
`define COLUMN_POST_SPRITE_BLITTER_UNIT_MACROS_SVH

// same-cycle implication
`define CPSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpsb check failed");

// next-cycle implication
`define CPSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpsb check failed");

`endif

/* hdl/cpsb_pkg.sv */
// shared types and constants for the column post sprite blitter
`timescale 1ns / 1ps
package cpsb_pkg;

  localparam logic [7:0] END_MARK = 8'hff;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TOP  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_PAD1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_PAD2 = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        done;
    logic [11:0] row;
    logic [10:0] x;
    logic [7:0]  value;
  } job_t;

endpackage

/* hdl/cpsb_queue.sv */
// short job queue between the post parser and the address stage
`timescale 1ns / 1ps
module cpsb_queue
  import cpsb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/cpsb_front.sv */
// post stream parser: takes items, tracks the post phase, emits jobs
`timescale 1ns / 1ps
module cpsb_front
  import cpsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        cmd,
  input  logic [10:0] col_x,
  input  logic [10:0] top_y,
  input  logic [7:0]  stream_byte,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  phase_t phase;
  phase_t phase_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [11:0] current_row;
  logic [11:0] current_row_next;
  logic [10:0] column_x;
  logic [10:0] sprite_top;
  logic accept;

  assign item_ready = !q_full;
  assign accept = item_valid && item_ready;

  always_comb begin
    phase_next = phase;
    bytes_left_next = bytes_left;
    current_row_next = current_row;
    push = 1'b0;
    push_job.done = 1'b0;
    push_job.row = current_row;
    push_job.x = column_x;
    push_job.value = stream_byte;
    if (accept) begin
      if (cmd == CMD_BEGIN) begin
        phase_next = PH_TOP;
        bytes_left_next = '0;
      end else begin
        unique case (phase)
          PH_TOP: begin
            if (stream_byte == END_MARK) begin
              phase_next = PH_IDLE;
              push = 1'b1;
              push_job.done = 1'b1;
            end else begin
              current_row_next = {sprite_top[10], sprite_top} + {4'b0, stream_byte};
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            bytes_left_next = stream_byte;
            phase_next = PH_PAD1;
          end
          PH_PAD1: begin
            phase_next = (bytes_left == '0) ? PH_PAD2 : PH_DATA;
          end
          PH_DATA: begin
            push = 1'b1;
            current_row_next = current_row + 1'b1;
            bytes_left_next = bytes_left - 1'b1;
            if (bytes_left == 8'd1) begin
              phase_next = PH_PAD2;
            end
          end
          PH_PAD2: begin
            phase_next = PH_TOP;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bytes_left <= '0;
      current_row <= '0;
      column_x <= '0;
      sprite_top <= '0;
    end else begin
      phase <= phase_next;
      bytes_left <= bytes_left_next;
      current_row <= current_row_next;
      if (accept && cmd == CMD_BEGIN) begin
        column_x <= col_x;
        sprite_top <= top_y;
      end
    end
  end

endmodule

/* hdl/cpsb_back.sv */
// address stage: turns jobs into framebuffer writes or column-done results, holds the result register
`timescale 1ns / 1ps
module cpsb_back
  import cpsb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        pixel_write,
  output logic [15:0] fb_address,
  output logic [7:0]  pixel_value,
  output logic [3:0]  plane_mask,
  output logic        off_screen,
  output logic        column_done
);

  localparam logic [15:0] LINE_BYTES = 16'(SCREEN_WIDTH);
  localparam logic [15:0] PLANE_LINE_BYTES = 16'(SCREEN_WIDTH / 4);
  localparam logic [11:0] WIDTH_LIM = 12'(SCREEN_WIDTH);
  localparam logic [11:0] HEIGHT_LIM = 12'(SCREEN_HEIGHT);

  logic planar;
  logic [15:0] row_ext;
  logic [15:0] x_ext;
  logic [15:0] xq_ext;
  logic [15:0] addr;
  logic [3:0] mask;
  logic off;

  assign pop = head_valid && (!result_valid || result_ready);

  always_comb begin
    row_ext = {{4{head_job.row[11]}}, head_job.row};
    x_ext = {{5{head_job.x[10]}}, head_job.x};
    xq_ext = {{7{head_job.x[10]}}, head_job.x[10:2]};
    if (planar) begin
      addr = row_ext * PLANE_LINE_BYTES + xq_ext;
      mask = 4'b0001 << head_job.x[1:0];
    end else begin
      addr = row_ext * LINE_BYTES + x_ext;
      mask = 4'hf;
    end
    off = head_job.row[11] || (head_job.row >= HEIGHT_LIM) ||
          head_job.x[10] || ({1'b0, head_job.x} >= WIDTH_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      planar <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        planar <= cfg_data;
      end
      if (pop) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_job.done) begin
        pixel_write <= 1'b0;
        fb_address <= '0;
        pixel_value <= '0;
        plane_mask <= '0;
        off_screen <= 1'b0;
        column_done <= 1'b1;
      end else begin
        pixel_write <= 1'b1;
        fb_address <= addr;
        pixel_value <= head_job.value;
        plane_mask <= mask;
        off_screen <= off;
        column_done <= 1'b0;
      end
    end
  end

endmodule

/* hdl/column_post_sprite_blitter_unit.sv */
// top level of the column post sprite blitter
//
//   channel   signals                                   accepted when
//   item      item_valid/item_ready, cmd, col_x, ...    item_valid && item_ready
//   result    result_valid/result_ready, pixel_write..  result_valid && result_ready
//   config    cfg_we, planar_mode                       cfg_we
//
// one item per cycle while item_ready is high; each data byte or end mark yields
// a result via the job queue, then the address multiply into the result register
// item_ready drops only while the four-entry job queue is full
// synchronous reset clears parser phase, queue and result valid
`timescale 1ns / 1ps
module column_post_sprite_blitter_unit
  import cpsb_pkg::*;
#(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        planar_mode,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        cmd,
  input  logic [10:0] col_x,
  input  logic [10:0] top_y,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        pixel_write,
  output logic [15:0] fb_address,
  output logic [7:0]  pixel_value,
  output logic [3:0]  plane_mask,
  output logic        off_screen,
  output logic        column_done
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  cpsb_front u_front (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .cmd(cmd),
    .col_x(col_x),
    .top_y(top_y),
    .stream_byte(stream_byte),
    .q_full(q_full),
    .push(push),
    .push_job(push_job)
  );

  cpsb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head_job(head_job)
  );

  cpsb_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(planar_mode),
    .head_valid(head_valid),
    .head_job(head_job),
    .pop(pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .pixel_write(pixel_write),
    .fb_address(fb_address),
    .pixel_value(pixel_value),
    .plane_mask(plane_mask),
    .off_screen(off_screen),
    .column_done(column_done)
  );

endmodule

/* hdl/cpsb_checker.sv */
// port-level checks for the column post sprite blitter, bound to the top level
`timescale 1ns / 1ps
`include "column_post_sprite_blitter_unit_macros.svh"
module cpsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic        pixel_write,
  input logic [15:0] fb_address,
  input logic [7:0]  pixel_value,
  input logic [3:0]  plane_mask,
  input logic        off_screen,
  input logic        column_done
);

  `CPSB_ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
                    result_valid && $stable(fb_address) && $stable(pixel_value)
                    && $stable(column_done))
  `CPSB_ASSERT_NOW(a_done_is_blank, result_valid && column_done,
                   !pixel_write && fb_address == 16'h0 && plane_mask == 4'h0
                   && !off_screen)
  `CPSB_ASSERT_NOW(a_write_mask, result_valid && pixel_write,
                   !column_done && (plane_mask == 4'hf || $onehot(plane_mask)))

endmodule

bind column_post_sprite_blitter_unit cpsb_checker u_cpsb_checker (.*);
